@@ sv/mdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_pkg: shared types and constants of the midpoint displacement pass
// Holds the controller/datapath command and status bundles, the register map
// and the shrink fraction table selected by variance_mode.
// ----------------------------------------------------------------------------
package mdp_pkg;

	// register map (index = byte address / 4)
	localparam logic       REG_VARIANCE_MODE = 1'b0;
	localparam logic [1:0] VARIANCE_MODE_RST = 2'd1;

	// variance_mode codes
	localparam logic [1:0] VM_LOW     = 2'd0;
	localparam logic [1:0] VM_MEDIUM  = 2'd1;
	localparam logic [1:0] VM_HIGH    = 2'd2;
	localparam logic [1:0] VM_QUARTER = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_in;      // capture the accepted input beat
		logic div_start;    // launch the sample modulo divider
		logic save_shrink;  // latch narrowed low end and span
		logic load_mid;     // load the midpoint into the output register
		logic load_pt;      // load the original point into the output register
		logic update_prev;  // move current point into previous
	} mdp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic fin;
	} mdp_sts_t;

	// numerator of the shrink fraction
	function automatic logic [1:0] shrink_num(input logic [1:0] mode);
		logic [1:0] n;
		case (mode)
			VM_LOW:     n = 2'd2;
			VM_MEDIUM:  n = 2'd1;
			VM_HIGH:    n = 2'd0;
			VM_QUARTER: n = 2'd1;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

	// denominator of the shrink fraction
	function automatic logic [2:0] shrink_den(input logic [1:0] mode);
		logic [2:0] d;
		case (mode)
			VM_LOW:     d = 3'd5;
			VM_MEDIUM:  d = 3'd5;
			VM_HIGH:    d = 3'd1;
			VM_QUARTER: d = 3'd4;
			default:    d = 3'd1;
		endcase
		return d;
	endfunction

endpackage

@@ sv/mdp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_div: restoring radix-2 divider
// One quotient bit per cycle; the remainder holds after done until the next
// start.
// ----------------------------------------------------------------------------
module mdp_div #(
	parameter int DW = 16,
	parameter int VW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [VW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= VW'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ sv/mdp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_dp: datapath of the midpoint displacement pass
// Input and previous point registers, range narrowing, the sample divider
// and the output payload register.
// ----------------------------------------------------------------------------
module mdp_dp
	import mdp_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mdp_cmd_t               cmd,
	output mdp_sts_t               sts,
	input  logic [1:0]             variance_mode,
	input  logic [COORD_BITS-1:0]  point_x,
	input  logic [COORD_BITS-1:0]  point_y,
	input  logic [SAMPLE_BITS-1:0] random_sample,
	input  logic                   final_point,
	output logic [COORD_BITS-1:0]  out_x,
	output logic [COORD_BITS-1:0]  out_y,
	output logic                   is_midpoint,
	output logic                   run_last
);

	localparam int C  = COORD_BITS;
	localparam int VW = C + 1;
	localparam int DW = SAMPLE_BITS;
	// floor(v/5) = (v * RECIP5) >> (C+3), exact for every v below 2^(C+1)
	localparam logic [C:0] RECIP5 = (C+1)'(((64'd1 << (C + 3)) + 64'd4) / 64'd5);

	logic [C-1:0]           cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                   fin_q;
	logic [C-1:0]           nlo_q;
	logic [VW-1:0]          span_q;
	logic [C-1:0]           out_x_q, out_y_q;
	logic                   is_mid_q, last_q;
	logic [C-1:0]           up_s1;
	logic [C:0]             sh_dvd_s1;

	logic [C-1:0]           lo, hi, t;
	logic [C:0]             sh_dvd, sh_qd;
	logic [2*C+1:0]         sh_prod;
	logic [C-1:0]           sh_quo;
	logic                   rem_nz;
	logic                   div_done;
	logic [VW-1:0]          rem;
	logic [C-1:0]           up;
	logic [C:0]             down;
	logic signed [C+1:0]    diff;
	logic [VW-1:0]          span;
	logic signed [C:0]      dx, dx_adj, half;
	logic [C:0]             mx;

	// capture the input beat and keep the previous point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (cmd.update_prev) begin
			prev_x_q <= fin_q ? '0 : cur_x_q;
			prev_y_q <= fin_q ? '0 : cur_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_x_q <= point_x;
			cur_y_q <= point_y;
			smp_q   <= random_sample;
			fin_q   <= final_point;
		end
	end

	// order the heights and build the shrink dividend t*n
	assign lo     = (prev_y_q < cur_y_q) ? prev_y_q : cur_y_q;
	assign hi     = (prev_y_q < cur_y_q) ? cur_y_q : prev_y_q;
	assign t      = hi - lo;
	assign sh_dvd = {1'b0, t} * (C+1)'(shrink_num(variance_mode));

	// shrink quotient: reciprocal multiply for fifths, shift for quarters
	assign sh_prod = (2*C+2)'(sh_dvd) * (2*C+2)'(RECIP5);

	always_comb begin
		case (variance_mode)
			VM_LOW, VM_MEDIUM: sh_quo = C'(sh_prod[2*C+1:C+3]);
			VM_QUARTER:        sh_quo = C'(sh_dvd[C:2]);
			default:           sh_quo = '0;  // no shrink
		endcase
	end

	always_ff @(posedge clk) begin
		up_s1     <= sh_quo;
		sh_dvd_s1 <= sh_dvd;
	end

	// a nonzero remainder rounds the high end cut up
	assign sh_qd  = {1'b0, up_s1} * (C+1)'(shrink_den(variance_mode));
	assign rem_nz = (sh_qd != sh_dvd_s1);

	mdp_div #(
		.DW(DW),
		.VW(VW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(smp_q),
		.divisor (span_q),
		.done    (div_done),
		.rem     (rem)
	);

	// floor for the low end, ceil for the high end, then the span
	assign up   = up_s1;
	assign down = {1'b0, up} + (C+1)'(rem_nz);
	assign diff = $signed({2'b00, hi}) - $signed({2'b00, lo})
	            - $signed({2'b00, up}) - $signed({1'b0, down});
	assign span = diff[C+1] ? VW'(1) : diff[C:0] + VW'(1);

	always_ff @(posedge clk) begin
		if (cmd.save_shrink) begin
			nlo_q  <= lo + up;
			span_q <= span;
		end
	end

	// midpoint x: later x minus half the gap, truncated toward zero
	assign dx     = $signed({1'b0, cur_x_q}) - $signed({1'b0, prev_x_q});
	assign dx_adj = dx + $signed({{C{1'b0}}, dx[C]});
	assign half   = dx_adj >>> 1;
	assign mx     = $unsigned($signed({1'b0, cur_x_q}) - half);

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_mid) begin
			out_x_q  <= mx[C-1:0];
			out_y_q  <= nlo_q + rem[C-1:0];
			is_mid_q <= 1'b1;
			last_q   <= 1'b0;
		end else if (cmd.load_pt) begin
			out_x_q  <= cur_x_q;
			out_y_q  <= cur_y_q;
			is_mid_q <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign sts.div_done = div_done;
	assign sts.fin      = fin_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign is_midpoint  = is_mid_q;
	assign run_last     = last_q;

endmodule

@@ sv/mdp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_ctrl: sequencer of the midpoint displacement pass
// Accepts a beat; when a previous point is held, narrows the height range and
// runs the sample modulo and releases the midpoint, then always the point, through the output register.
// ----------------------------------------------------------------------------
module mdp_ctrl
	import mdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  mdp_sts_t sts,
	output mdp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHRINK,
		ST_SH_SAVE,
		ST_MD_GO,
		ST_MD_WAIT,
		ST_MID,
		ST_PT
	} state_t;

	state_t state_q;
	logic   have_prev_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// decode commands from state
	always_comb begin
		cmd             = '0;
		cmd.load_in     = accept;
		cmd.div_start   = (state_q == ST_MD_GO);
		cmd.save_shrink = (state_q == ST_SH_SAVE);
		cmd.load_mid    = (state_q == ST_MID) && out_free;
		cmd.load_pt     = (state_q == ST_PT) && out_free;
		cmd.update_prev = cmd.load_pt;
	end

	// hold state, pass flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_mid || cmd.load_pt)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= have_prev_q ? ST_SHRINK : ST_PT;
				end
				ST_SHRINK:  state_q <= ST_SH_SAVE;
				ST_SH_SAVE: state_q <= ST_MD_GO;
				ST_MD_GO:   state_q <= ST_MD_WAIT;
				ST_MD_WAIT: begin
					if (sts.div_done)
						state_q <= ST_MID;
				end
				ST_MID: begin
					if (out_free)
						state_q <= ST_PT;
				end
				ST_PT: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						have_prev_q <= !sts.fin;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/midpoint_displacement_pass.sv @@
`timescale 1ns / 1ps
// Flow: the first point of a pass goes from accept to the point state and on to
// the output register; a later point runs the shrink, save, divider start and
// divider wait states before its midpoint is loaded, and the point shows in the
// cycle after the midpoint is taken. A beat with a previous point runs range
// narrowing, divider start, SAMPLE_BITS radix-2 steps, handoff and output; in_stall holds off the next beat until then.
// Reset: arst_n clears the pass and the output valid and sets variance_mode to 1.
// ----------------------------------------------------------------------------
// midpoint_displacement_pass: one 1D midpoint displacement subdivision pass
// Register port, sequencer and datapath of the block.
// ----------------------------------------------------------------------------
module midpoint_displacement_pass
	import mdp_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_BITS-1:0]  point_x,
	input  logic [COORD_BITS-1:0]  point_y,
	input  logic [SAMPLE_BITS-1:0] random_sample,
	input  logic                   final_point,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_BITS-1:0]  out_x,
	output logic [COORD_BITS-1:0]  out_y,
	output logic                   is_midpoint,
	output logic                   run_last
);

	logic [1:0] variance_mode_q;
	mdp_cmd_t   cmd;
	mdp_sts_t   sts;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			variance_mode_q <= VARIANCE_MODE_RST;
		else if (psel && penable && pwrite && (paddr[2] == REG_VARIANCE_MODE))
			variance_mode_q <= pwdata[1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VARIANCE_MODE) ? {30'd0, variance_mode_q} : 32'd0;

	mdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mdp_dp #(
		.COORD_BITS (COORD_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.variance_mode(variance_mode_q),
		.point_x      (point_x),
		.point_y      (point_y),
		.random_sample(random_sample),
		.final_point  (final_point),
		.out_x        (out_x),
		.out_y        (out_y),
		.is_midpoint  (is_midpoint),
		.run_last     (run_last)
	);

endmodule

@@ sv/mdp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdp_checker: port-level checks of the midpoint displacement pass
// Watches the handshakes and result flags seen on the top level.
// ----------------------------------------------------------------------------
module mdp_checker #(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [COORD_BITS-1:0] out_x,
	input logic [COORD_BITS-1:0] out_y,
	input logic                  is_midpoint,
	input logic                  run_last
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
		&& $stable(is_midpoint) && $stable(run_last))
		else $error("stalled result beat changed");

	// stall input while an accepted beat is at work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous beat still at work");

	// a midpoint is never the last result of its beat, a point always is
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_midpoint != run_last))
		else $error("run_last does not match result kind");

	// the point of a beat still follows a shown midpoint
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_midpoint |-> in_stall)
		else $error("input released before the point of its midpoint");

endmodule

bind midpoint_displacement_pass mdp_checker #(
	.COORD_BITS(COORD_BITS)
) u_mdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_x      (out_x),
	.out_y      (out_y),
	.is_midpoint(is_midpoint),
	.run_last   (run_last)
);
